// ----- sv/sleep_state_package_scanner_core_defines.svh -----
// Assertion macros for the checker file of the sleep state package scanner.
`ifndef SLEEP_STATE_PACKAGE_SCANNER_CORE_DEFINES_SVH
`define SLEEP_STATE_PACKAGE_SCANNER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define SSPSC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sspsc assertion failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define SSPSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sspsc assertion failed");

`endif

// ----- sv/sspsc_pkg.sv -----
// Package: types, constants and helper functions of the sleep state package scanner.
package sspsc_pkg;

  // Default length of the fixed table header in bytes.
  localparam int unsigned HeaderBytesDefault = 36;

  // Byte codes of the scanned body.
  localparam logic [7:0] NameOp    = 8'h08;
  localparam logic [7:0] PkgOp     = 8'h12;
  localparam logic [7:0] BytePrefix = 8'h0A;

  // Characters of the package name between the opcodes.
  localparam logic [7:0] Underscore = 8'h5F;
  localparam logic [7:0] LetterS    = 8'h53;
  localparam logic [7:0] Digit5     = 8'h35;

  // Sleep word layout and reset value of the fallback word.
  localparam logic [15:0] FallbackReset = 16'h2000;
  localparam int unsigned TypeW         = 3;
  localparam int unsigned TypeShift     = 10;
  localparam int unsigned WordW         = 16;

  // Stream widths.
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;

  // Scan phases, one-hot.
  typedef enum logic [13:0] {
    PhIdle   = 14'b00000000000001,
    PhM1     = 14'b00000000000010,
    PhM2     = 14'b00000000000100,
    PhM3     = 14'b00000000001000,
    PhM4     = 14'b00000000010000,
    PhM5     = 14'b00000000100000,
    PhLead   = 14'b00000001000000,
    PhSkip   = 14'b00000010000000,
    PhCount  = 14'b00000100000000,
    PhTa     = 14'b00001000000000,
    PhTaVal  = 14'b00010000000000,
    PhTb     = 14'b00100000000000,
    PhTbVal  = 14'b01000000000000,
    PhDone   = 14'b10000000000000
  } phase_e;

  // One result transaction.
  typedef struct packed {
    logic              sum_valid;
    logic              package_found;
    logic [WordW-1:0]  sleep_word_a;
    logic [WordW-1:0]  sleep_word_b;
  } result_t;

  // Sleep word for a type value.
  function automatic logic [WordW-1:0] type_word(input logic [TypeW-1:0] t);
    logic [WordW-1:0] w;
    w = WordW'(t) << TypeShift;
    return w;
  endfunction

endpackage

// ----- sv/sspsc_scan.sv -----
// Scanner state: checksum, header count, pattern match and sleep type capture.
module sspsc_scan #(
  parameter int unsigned HeaderBytes = sspsc_pkg::HeaderBytesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [7:0]                   byte_i,
  input  logic                         last_i,
  input  logic [sspsc_pkg::WordW-1:0]  fallback_i,
  output sspsc_pkg::result_t           result_o
);

  localparam int unsigned CntW = (HeaderBytes > 0) ? $clog2(HeaderBytes + 1) : 1;
  localparam logic [CntW-1:0] HdrLast = CntW'(HeaderBytes);

  logic [CntW-1:0]               hdr_q, hdr_d;
  logic [7:0]                    sum_q, sum_d;
  sspsc_pkg::phase_e             phase_q, phase_d;
  logic [1:0]                    skip_q, skip_d;
  logic [sspsc_pkg::TypeW-1:0]   ta_q, ta_d;
  logic [sspsc_pkg::TypeW-1:0]   tb_q, tb_d;
  logic                          found_q, found_d;
  sspsc_pkg::phase_e             miss_ph;

  // Restart target on a pattern mismatch
  assign miss_ph = (byte_i == sspsc_pkg::NameOp) ? sspsc_pkg::PhM1 : sspsc_pkg::PhIdle;

  // Next state for one byte
  always_comb begin
    hdr_d   = hdr_q;
    sum_d   = sum_q + byte_i;
    phase_d = phase_q;
    skip_d  = skip_q;
    ta_d    = ta_q;
    tb_d    = tb_q;
    found_d = found_q;
    if (hdr_q < HdrLast) begin
      hdr_d = hdr_q + 1'b1;
    end else begin
      unique case (phase_q)
        sspsc_pkg::PhIdle: phase_d = miss_ph;
        sspsc_pkg::PhM1: begin
          phase_d = (byte_i == sspsc_pkg::Underscore) ? sspsc_pkg::PhM2 : miss_ph;
        end
        sspsc_pkg::PhM2: begin
          phase_d = (byte_i == sspsc_pkg::LetterS) ? sspsc_pkg::PhM3 : miss_ph;
        end
        sspsc_pkg::PhM3: begin
          phase_d = (byte_i == sspsc_pkg::Digit5) ? sspsc_pkg::PhM4 : miss_ph;
        end
        sspsc_pkg::PhM4: begin
          phase_d = (byte_i == sspsc_pkg::Underscore) ? sspsc_pkg::PhM5 : miss_ph;
        end
        sspsc_pkg::PhM5: begin
          phase_d = (byte_i == sspsc_pkg::PkgOp) ? sspsc_pkg::PhLead : miss_ph;
        end
        sspsc_pkg::PhLead: begin
          skip_d  = byte_i[7:6];
          phase_d = (byte_i[7:6] != 2'd0) ? sspsc_pkg::PhSkip : sspsc_pkg::PhCount;
        end
        sspsc_pkg::PhSkip: begin
          skip_d = skip_q - 2'd1;
          if (skip_q == 2'd1) phase_d = sspsc_pkg::PhCount;
        end
        sspsc_pkg::PhCount: phase_d = sspsc_pkg::PhTa;
        sspsc_pkg::PhTa: begin
          if (byte_i == sspsc_pkg::BytePrefix) begin
            phase_d = sspsc_pkg::PhTaVal;
          end else begin
            ta_d    = byte_i[sspsc_pkg::TypeW-1:0];
            phase_d = sspsc_pkg::PhTb;
          end
        end
        sspsc_pkg::PhTaVal: begin
          ta_d    = byte_i[sspsc_pkg::TypeW-1:0];
          phase_d = sspsc_pkg::PhTb;
        end
        sspsc_pkg::PhTb: begin
          if (byte_i == sspsc_pkg::BytePrefix) begin
            phase_d = sspsc_pkg::PhTbVal;
          end else begin
            tb_d    = byte_i[sspsc_pkg::TypeW-1:0];
            found_d = 1'b1;
            phase_d = sspsc_pkg::PhDone;
          end
        end
        sspsc_pkg::PhTbVal: begin
          tb_d    = byte_i[sspsc_pkg::TypeW-1:0];
          found_d = 1'b1;
          phase_d = sspsc_pkg::PhDone;
        end
        default: phase_d = sspsc_pkg::PhDone;
      endcase
    end
  end

  // Result of a last byte, from the updated state
  always_comb begin
    result_o.sum_valid     = (sum_d == 8'd0);
    result_o.package_found = found_d;
    if (sum_d != 8'd0) begin
      result_o.sleep_word_a = '0;
      result_o.sleep_word_b = '0;
    end else if (found_d) begin
      result_o.sleep_word_a = sspsc_pkg::type_word(ta_d);
      result_o.sleep_word_b = sspsc_pkg::type_word(tb_d);
    end else begin
      result_o.sleep_word_a = fallback_i;
      result_o.sleep_word_b = fallback_i;
    end
  end

  // State registers; a last byte returns everything to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q   <= '0;
      sum_q   <= '0;
      phase_q <= sspsc_pkg::PhIdle;
      skip_q  <= '0;
      ta_q    <= '0;
      tb_q    <= '0;
      found_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        hdr_q   <= '0;
        sum_q   <= '0;
        phase_q <= sspsc_pkg::PhIdle;
        skip_q  <= '0;
        ta_q    <= '0;
        tb_q    <= '0;
        found_q <= 1'b0;
      end else begin
        hdr_q   <= hdr_d;
        sum_q   <= sum_d;
        phase_q <= phase_d;
        skip_q  <= skip_d;
        ta_q    <= ta_d;
        tb_q    <= tb_d;
        found_q <= found_d;
      end
    end
  end

endmodule

// ----- sv/sleep_state_package_scanner_core.sv -----
// Top level of the sleep state package scanner: input register, scanner, result register.
//
// Input stream (s_axis_*): one table byte per transaction, header first, tlast on the
// final byte of the table. Output stream (m_axis_*): one result transaction per table,
// issued after its final byte. Configuration: cfg_we_i writes cfg_wdata_i into the
// fallback sleep word (reset 0x2000); write it only while no table is in flight.
// Result path: a final byte is taken into the input register, and its result is then
// registered in the result register, from which it shows on m_axis.
// Throughput: one byte per cycle; s_axis_tready stays high as long as the result
// register can take or has delivered the previous result.
// Stall: a result waits in the output register while m_axis_tready is low; further
// non-final bytes keep flowing in, and only the next final byte waits in the input
// register until the result is taken, which then holds s_axis_tready low.
// Reset: clears the scanner state and both valid flags and sets the fallback word to
// 0x2000; all scanner state also clears on each final byte.
module sleep_state_package_scanner_core #(
  parameter int unsigned HeaderBytes = sspsc_pkg::HeaderBytesDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [sspsc_pkg::InDataW-1:0]     s_axis_tdata,  // [7:0] table_byte
  input  logic                              s_axis_tlast,  // final_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] sum_valid, [1] package_found, [17:2] sleep_word_a, [33:18] sleep_word_b,
  // [39:34] zero
  output logic [sspsc_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [sspsc_pkg::WordW-1:0]       cfg_wdata_i
);

  logic                          in_valid_q;
  logic [7:0]                    in_byte_q;
  logic                          in_last_q;
  logic                          advance;
  logic [sspsc_pkg::WordW-1:0]   fallback_q;
  sspsc_pkg::result_t            result;
  logic                          out_valid_q;
  sspsc_pkg::result_t            out_q;

  // A non-final byte never needs the result register
  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fallback_q <= sspsc_pkg::FallbackReset;
    end else if (cfg_we_i) begin
      fallback_q <= cfg_wdata_i;
    end
  end

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  sspsc_scan #(
    .HeaderBytes (HeaderBytes)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .byte_i     (in_byte_q),
    .last_i     (in_last_q),
    .fallback_i (fallback_q),
    .result_o   (result)
  );

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.sleep_word_b, out_q.sleep_word_a,
                          out_q.package_found, out_q.sum_valid};

endmodule

// ----- sv/sspsc_checker.sv -----
// Port-level checker of the sleep state package scanner, bound to the top level.
`include "sleep_state_package_scanner_core_defines.svh"

module sspsc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sspsc_pkg::OutDataW-1:0]  m_axis_tdata
);

  // An empty result register never blocks the input
  `SSPSC_ASSERT_IMPL(a_in_ready, !m_axis_tvalid, s_axis_tready)

  // A stalled result holds its value
  `SSPSC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // Padding above the result fields stays zero
  `SSPSC_ASSERT_IMPL(a_out_pad, m_axis_tvalid, m_axis_tdata[39:34] == 6'd0)

  // Bad checksum reports both sleep words as zero
  `SSPSC_ASSERT_IMPL(a_bad_sum, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[33:2] == 32'd0)

  // Good checksum without package gives two equal fallback words
  `SSPSC_ASSERT_IMPL(a_fallback, m_axis_tvalid && m_axis_tdata[0] && !m_axis_tdata[1], m_axis_tdata[17:2] == m_axis_tdata[33:18])

endmodule

bind sleep_state_package_scanner_core sspsc_checker u_sspsc_checker (.*);

// ----- tb/sv/tb.sv -----
// Testbench of the sleep state package scanner: table stimulus, prediction, result check.
module tb;
  import sspsc_pkg::*;

  localparam int unsigned LongHold     = 400;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned PhaseBytes   = 230;
  localparam int unsigned PhaseTables  = 4;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } table_item_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // Block inputs, known from time zero
  logic                s_axis_tvalid = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tready = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [WordW-1:0]    cfg_wdata_i   = '0;

  // Block outputs
  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic [OutDataW-1:0] m_axis_tdata;

  sleep_state_package_scanner_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Stimulus and scoreboard storage
  table_item_t pending_items[$];
  logic [7:0]  table_bytes[$];
  result_t     expected_reports[$];
  int unsigned queued_bytes   = 0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_stall_pct   = 0;
  int unsigned hold_req_count = 0;
  int unsigned hold_req_seen  = 0;
  int unsigned hold_left      = 0;
  logic        in_fire        = 1'b0;

  // Scanner model state
  logic [15:0] fallback_model = FallbackReset;
  int unsigned hdr_seen       = 0;
  logic [7:0]  byte_sum       = '0;
  phase_e      scan_ph        = PhIdle;
  logic [1:0]  skip_cnt       = '0;
  logic [2:0]  type_a         = '0;
  logic [2:0]  type_b         = '0;
  logic        pkg_seen       = 1'b0;

  // Pattern step: advance on the wanted byte, else restart (a name op restarts at one match)
  function automatic phase_e match_next(input logic [7:0] b, input logic [7:0] want,
                                        input phase_e nxt);
    if (b == want) return nxt;
    return (b == NameOp) ? PhM1 : PhIdle;
  endfunction

  // Fold one accepted table byte into the model; returns 1 with the report on a final byte
  function automatic bit absorb_table_byte(input logic [7:0] b, input logic last,
                                           output result_t rpt);
    rpt = '0;
    byte_sum = byte_sum + b;
    if (hdr_seen < HeaderBytesDefault) begin
      hdr_seen++;
    end else begin
      case (scan_ph)
        PhIdle:  scan_ph = match_next(b, NameOp, PhM1);
        PhM1:    scan_ph = match_next(b, Underscore, PhM2);
        PhM2:    scan_ph = match_next(b, LetterS, PhM3);
        PhM3:    scan_ph = match_next(b, Digit5, PhM4);
        PhM4:    scan_ph = match_next(b, Underscore, PhM5);
        PhM5:    scan_ph = match_next(b, PkgOp, PhLead);
        PhLead: begin
          skip_cnt = b[7:6];
          scan_ph  = (skip_cnt != 0) ? PhSkip : PhCount;
        end
        PhSkip: begin
          skip_cnt = skip_cnt - 1'b1;
          if (skip_cnt == 0) scan_ph = PhCount;
        end
        PhCount: scan_ph = PhTa;
        PhTa: begin
          if (b == BytePrefix) begin
            scan_ph = PhTaVal;
          end else begin
            type_a  = b[2:0];
            scan_ph = PhTb;
          end
        end
        PhTaVal: begin
          type_a  = b[2:0];
          scan_ph = PhTb;
        end
        PhTb: begin
          if (b == BytePrefix) begin
            scan_ph = PhTbVal;
          end else begin
            type_b   = b[2:0];
            pkg_seen = 1'b1;
            scan_ph  = PhDone;
          end
        end
        PhTbVal: begin
          type_b   = b[2:0];
          pkg_seen = 1'b1;
          scan_ph  = PhDone;
        end
        default: scan_ph = PhDone;
      endcase
    end
    if (!last) return 1'b0;
    rpt.sum_valid     = (byte_sum == 8'h00);
    rpt.package_found = pkg_seen;
    if (!rpt.sum_valid) begin
      rpt.sleep_word_a = '0;
      rpt.sleep_word_b = '0;
    end else if (pkg_seen) begin
      rpt.sleep_word_a = WordW'(type_a) << TypeShift;
      rpt.sleep_word_b = WordW'(type_b) << TypeShift;
    end else begin
      rpt.sleep_word_a = fallback_model;
      rpt.sleep_word_b = fallback_model;
    end
    // every table starts from a clean scan
    hdr_seen = 0;
    byte_sum = '0;
    scan_ph  = PhIdle;
    skip_cnt = '0;
    type_a   = '0;
    type_b   = '0;
    pkg_seen = 1'b0;
    return 1'b1;
  endfunction

  task automatic check_field(input string label, input logic [15:0] want,
                             input logic [15:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, seen);
      error_count++;
    end
  endtask

  // Input stream driver: holds an item until its transaction completes
  always @(negedge clk_i) begin : stream_driver
    logic        nxt_valid;
    table_item_t nxt;
    nxt_valid = s_axis_tvalid;
    nxt       = '{value: s_axis_tdata, last: s_axis_tlast};
    if (in_fire) begin
      void'(pending_items.pop_front());
      nxt_valid = 1'b0;
    end
    if (!nxt_valid && rst_ni && pending_items.size() != 0 &&
        $urandom_range(99) >= tx_idle_pct) begin
      nxt_valid = 1'b1;
      nxt       = pending_items[0];
    end
    s_axis_tvalid <= nxt_valid;
    s_axis_tdata  <= nxt.value;
    s_axis_tlast  <= nxt.last;
  end

  // Result ready: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin : result_ready
    logic rdy;
    if (hold_req_seen != hold_req_count) begin
      hold_req_seen = hold_req_count;
      hold_left     = LongHold;
    end
    if (hold_left != 0) begin
      hold_left--;
      rdy = 1'b0;
    end else begin
      rdy = ($urandom_range(99) >= rx_stall_pct);
    end
    m_axis_tready <= rdy;
  end

  // Monitor: check result transactions, predict from input transactions
  always @(posedge clk_i) begin : stream_monitor
    result_t             want;
    logic [OutDataW-1:0] seen;
    if (!rst_ni) begin
      in_fire = 1'b0;
    end else begin
      if (cfg_we_i) fallback_model = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        seen = m_axis_tdata;
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, seen);
          error_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("sum_valid", 16'(want.sum_valid), 16'(seen[0]));
          check_field("package_found", 16'(want.package_found), 16'(seen[1]));
          check_field("sleep_word_a", want.sleep_word_a, seen[17:2]);
          check_field("sleep_word_b", want.sleep_word_b, seen[33:18]);
          check_field("pad bits", 16'h0000, 16'(seen[39:34]));
        end
      end
      in_fire = s_axis_tvalid && s_axis_tready;
      if (in_fire && absorb_table_byte(s_axis_tdata, s_axis_tlast, want))
        expected_reports.push_back(want);
    end
  end

  // Table construction helpers
  function automatic logic [7:0] pick_body_byte();
    case ($urandom_range(7))
      0:       return NameOp;
      1:       return Underscore;
      2:       return LetterS;
      3:       return Digit5;
      4:       return PkgOp;
      5:       return BytePrefix;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic add_header(input int unsigned n);
    repeat (n) table_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic add_noise(input int unsigned n);
    repeat (n) table_bytes.push_back(pick_body_byte());
  endtask

  // Name, package op, length lead and extras, count, then two optionally prefixed types
  task automatic add_sleep_package(input logic [1:0] extra, input bit pre_a, input bit pre_b,
                                   input logic [7:0] ta, input logic [7:0] tb);
    table_bytes.push_back(NameOp);
    table_bytes.push_back(Underscore);
    table_bytes.push_back(LetterS);
    table_bytes.push_back(Digit5);
    table_bytes.push_back(Underscore);
    table_bytes.push_back(PkgOp);
    table_bytes.push_back({extra, 6'($urandom_range(63))});
    repeat (extra) table_bytes.push_back(8'($urandom_range(255)));
    table_bytes.push_back(8'($urandom_range(255)));
    if (pre_a) table_bytes.push_back(BytePrefix);
    table_bytes.push_back(ta);
    if (pre_b) table_bytes.push_back(BytePrefix);
    table_bytes.push_back(tb);
  endtask

  // Fix the last byte for a good or bad checksum and hand the table to the driver
  task automatic commit_table(input bit good_sum);
    logic [7:0]  total;
    int unsigned n;
    total = '0;
    n     = table_bytes.size();
    for (int unsigned i = 0; i + 1 < n; i++) total = total + table_bytes[i];
    if (good_sum) table_bytes[n-1] = 8'h00 - total;
    else if (8'(total + table_bytes[n-1]) == 8'h00) table_bytes[n-1] = table_bytes[n-1] + 1'b1;
    for (int unsigned i = 0; i < n; i++)
      pending_items.push_back('{value: table_bytes[i], last: (i + 1 == n)});
    queued_bytes += n;
    table_bytes.delete();
  endtask

  // Mostly well-formed tables with random content, the rest broken or noise
  task automatic run_random_tables(input int unsigned budget);
    int unsigned start_bytes;
    int unsigned tables;
    int unsigned kind;
    start_bytes = queued_bytes;
    tables      = 0;
    while (queued_bytes - start_bytes < budget || tables < PhaseTables) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        add_header(HeaderBytesDefault);
        add_noise($urandom_range(4));
        add_sleep_package(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                          pick_body_byte(), pick_body_byte());
        add_noise($urandom_range(4));
        if ($urandom_range(4) == 0)
          add_sleep_package(2'($urandom_range(3)), 1'($urandom_range(1)),
                            1'($urandom_range(1)), 8'($urandom_range(255)),
                            8'($urandom_range(255)));
      end else if (kind < 75) begin
        // package cut off before its end
        add_header(HeaderBytesDefault);
        add_noise($urandom_range(2));
        add_sleep_package(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                          8'($urandom_range(255)), 8'($urandom_range(255)));
        repeat ($urandom_range(1, 10)) void'(table_bytes.pop_back());
      end else if (kind < 90) begin
        add_header(HeaderBytesDefault);
        add_noise($urandom_range(1, 20));
      end else begin
        add_header($urandom_range(1, 40));
      end
      commit_table($urandom_range(3) != 0);
      tables++;
    end
  endtask

  task automatic drain_all();
    while (pending_items.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_fallback(input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Sequence of phases
  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed tables at the reset fallback word
    table_bytes.push_back(8'h00);
    commit_table(1'b1);
    table_bytes.push_back(8'hFF);
    commit_table(1'b0);
    add_header(HeaderBytesDefault);
    add_sleep_package(2'd0, 1'b0, 1'b0, 8'hFF, 8'h00);
    commit_table(1'b1);
    add_header(HeaderBytesDefault);
    add_sleep_package(2'd3, 1'b1, 1'b1, BytePrefix, 8'h05);
    table_bytes.push_back(8'h00);
    commit_table(1'b1);
    // partial match broken by a name op, which restarts the match
    add_header(HeaderBytesDefault);
    table_bytes.push_back(NameOp);
    table_bytes.push_back(Underscore);
    table_bytes.push_back(LetterS);
    table_bytes.push_back(NameOp);
    add_sleep_package(2'd1, 1'b0, 1'b1, 8'h04, 8'h03);
    table_bytes.push_back(8'h00);
    commit_table(1'b1);
    // second package must be ignored
    add_header(HeaderBytesDefault);
    add_sleep_package(2'd1, 1'b0, 1'b1, 8'h03, 8'h06);
    add_sleep_package(2'd0, 1'b0, 1'b0, 8'h01, 8'h01);
    table_bytes.push_back(8'h00);
    commit_table(1'b1);
    // table ends inside the length bytes
    add_header(HeaderBytesDefault);
    add_sleep_package(2'd2, 1'b0, 1'b0, 8'h02, 8'h02);
    repeat (4) void'(table_bytes.pop_back());
    commit_table(1'b1);
    // bad checksum with a found package
    add_header(HeaderBytesDefault);
    add_sleep_package(2'd0, 1'b1, 1'b0, 8'h07, 8'h07);
    table_bytes.push_back(8'h00);
    commit_table(1'b0);
    // header only, one short of the header, and a table ending mid-pattern
    add_header(HeaderBytesDefault);
    commit_table(1'b1);
    add_header(HeaderBytesDefault - 1);
    commit_table(1'b1);
    add_header(HeaderBytesDefault);
    add_sleep_package(2'd0, 1'b0, 1'b0, 8'h00, 8'h00);
    repeat (5) void'(table_bytes.pop_back());
    commit_table(1'b1);
    drain_all();

    // No idling
    write_fallback(16'hFFFF);
    run_random_tables(PhaseBytes);
    drain_all();

    // Sender idle most of the time
    write_fallback(16'h0000);
    tx_idle_pct = 64;
    run_random_tables(PhaseBytes);
    drain_all();

    // Receiver stalling most of the time
    write_fallback(16'($urandom_range(65535)));
    tx_idle_pct  = 0;
    rx_stall_pct = 64;
    run_random_tables(PhaseBytes);
    drain_all();

    // Both sides idling now and then
    write_fallback(16'($urandom_range(65535)));
    tx_idle_pct  = 20;
    rx_stall_pct = 20;
    run_random_tables(PhaseBytes);
    drain_all();

    // Long receiver hold-off while the sender keeps offering bytes
    write_fallback(FallbackReset);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req_count++;
    run_random_tables(PhaseBytes);
    drain_all();

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
